[rtl/tkls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tkls_pkg;

  localparam int KMax   = 16;
  localparam int DataW  = 32;
  localparam int CountW = 5;
  // Width of an index or a count that can reach KMax itself.
  localparam int IdxW   = $clog2(KMax + 1);

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value_res;
    logic                    last_res;
  } result_t;

  // What the chain does this cycle; shared by every cell.
  typedef struct packed {
    logic                    ins;
    logic                    drain;
    logic signed [DataW-1:0] din;
  } chain_ctl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    ge;
    logic signed [DataW-1:0] value;
  } link_t;

endpackage

`default_nettype wire

[rtl/top_k_largest_select.sv]
// Channel  | Signals               | Transfer
// ---------+-----------------------+-------------------------------
// item     | start, busy, item     | rising edge with start && !busy
// result   | strobe, result        | every cycle strobe is high
// config   | cfg_we, cfg_wdata     | rising edge with cfg_we high
//
// A new element is taken whenever busy is low: every cell compares it with its own entry
// in parallel and the chain shifts smaller entries down by one slot.
// After the element marked last, the chain shifts its n kept values out of
// cell 0, one per cycle, largest first; busy stays high until the last of them is shown.
// rst (synchronous) empties the chain and sets the count to 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module top_k_largest_select
  import tkls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire item_t             item,
  input  wire logic              cfg_we,
  input  wire logic [CountW-1:0] cfg_wdata,
  output logic                   strobe,
  output result_t                result
);

  logic [CountW-1:0] top_count;
  logic [IdxW-1:0]   keff;
  logic              draining;
  logic              accept;
  chain_ctl_t        ctl;
  link_t             links   [KMax];
  link_t             prev_of [KMax];
  link_t             next_of [KMax];

  // Config register; the user must write it only while idle, the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= CountW'(1);
    end else if (cfg_we) begin
      top_count <= cfg_wdata;
    end
  end

  // Zero acts as one, anything above the chain length as the full chain.
  always_comb begin
    if (top_count == '0) begin
      keff = IdxW'(1);
    end else if (32'(top_count) > KMax) begin
      keff = IdxW'(KMax);
    end else begin
      keff = IdxW'(top_count);
    end
  end

  assign busy   = draining;
  assign accept = start && !draining;

  assign ctl.ins   = accept;
  assign ctl.drain = draining;
  assign ctl.din   = item.value;

  // Neighbor wiring: cell 0 always sees a "larger" neighbor above it, the
  // last cell sees an empty slot below it.
  for (genvar i = 0; i < KMax; i++) begin : g_wire
    if (i == 0) begin : g_head
      assign prev_of[i] = '{valid: 1'b0, ge: 1'b1, value: '0};
    end else begin : g_mid
      assign prev_of[i] = links[i-1];
    end
    if (i == KMax - 1) begin : g_tail
      assign next_of[i] = '{valid: 1'b0, ge: 1'b0, value: '0};
    end else begin : g_body
      assign next_of[i] = links[i+1];
    end

    tkls_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .en        (IdxW'(i) < keff),
      .prev_link (prev_of[i]),
      .next_link (next_of[i]),
      .link      (links[i])
    );
  end

  // Output straight from cell 0 while unloading.
  assign strobe           = draining && links[0].valid;
  assign result.value_res = links[0].value;
  assign result.last_res  = !next_of[0].valid;

  // After a set's last element the chain always holds at least one entry
  // (an empty chain takes the element into cell 0, a non-empty one keeps
  // cell 0), so the unload has at least one transfer and ends on the one
  // flagged last_res.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (accept && item.last) begin
      draining <= 1'b1;
    end else if (strobe && result.last_res) begin
      draining <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/tkls_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module tkls_cell
  import tkls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire chain_ctl_t ctl,
  input  wire logic       en,        // slot lies below the effective count
  input  wire link_t      prev_link, // toward the largest entry
  input  wire link_t      next_link, // toward the smallest entry
  output link_t           link
);

  logic signed [DataW-1:0] value;
  logic                    valid;

  // Entry stays put when it is at least as large as the incoming value.
  assign link.valid = valid;
  assign link.value = value;
  assign link.ge    = valid && en && (value >= ctl.din);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      valid <= next_link.valid;
      value <= next_link.value;
    end else if (ctl.ins) begin
      if (!en) begin
        valid <= 1'b0;
      end else if (link.ge) begin
        valid <= valid;
      end else if (prev_link.ge) begin
        valid <= 1'b1;
        value <= ctl.din;
      end else begin
        valid <= prev_link.valid;
        value <= prev_link.value;
      end
    end
  end

endmodule

`default_nettype wire
